// ===== rtl/core/capture_point_foot_offset_core_macros.svh =====
// Assertion macros for the foot offset core.
// Used by capture_point_foot_offset_core; needs no other file.
`ifndef CAPTURE_POINT_FOOT_OFFSET_CORE_MACROS_SVH
`define CAPTURE_POINT_FOOT_OFFSET_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CPFO_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) (ante) |-> (cons)) \
		else $error("implication failed");
`define CPFO_ASSERT_NEVER(lbl, clk_s, rst_n_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n_s)) !(cond)) \
		else $error("forbidden condition seen");
`else
`define CPFO_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons)
`define CPFO_ASSERT_NEVER(lbl, clk_s, rst_n_s, cond)
`endif

`endif

// ===== rtl/core/cpfo_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the foot offset core.
// No dependencies.
package cpfo_pkg;

	localparam int CPFO_FRAC_BITS = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int GAIN_W = 24;
	localparam int GRAV_W = 23;
	localparam int HGT_W  = 31;
	localparam int LIM_W  = 31;
	localparam int MAG_W  = 32;
	localparam int LEN_W  = 32;

	localparam logic [GAIN_W-1:0] GAIN_RST = 24'd65536;
	localparam logic [GRAV_W-1:0] GRAV_RST = 23'd642908;
	localparam logic [HGT_W-1:0]  HOV_RST  = 31'd0;
	localparam logic [HGT_W-1:0]  NOM_RST  = 31'd65536;
	localparam logic [LIM_W-1:0]  LIM_RST  = 31'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN    = 3'd0,
		CFG_GRAVITY = 3'd1,
		CFG_HGT_OVR = 3'd2,
		CFG_NOM_HGT = 3'd3,
		CFG_MAX_OFS = 3'd4
	} cpfo_cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] measured_height;
		logic signed [31:0] measured_vel_x;
		logic signed [31:0] measured_vel_y;
		logic signed [31:0] commanded_vel_x;
		logic signed [31:0] commanded_vel_y;
	} cpfo_in_t;

	typedef struct packed {
		logic signed [31:0] offset_x;
		logic signed [31:0] offset_y;
		logic               was_clamped;
		logic               no_valid_height;
	} cpfo_out_t;

endpackage

// ===== rtl/core/cpfo_div_pipe.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage, lanes share one divisor.
// Standalone; payload rides along with the valid bit.
module cpfo_div_pipe #(
	parameter int DW    = 23,
	parameter int QB    = 63,
	parameter int LANES = 1,
	parameter int PW    = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [LANES-1:0][DW-1:0]     rem_in,
	input  logic [LANES-1:0][QB-1:0]     lo_in,
	input  logic [DW-1:0]                div_in,
	input  logic [PW-1:0]                pay_in,
	output logic                         out_vld,
	output logic [LANES-1:0][QB-1:0]     quo_out,
	output logic [PW-1:0]                pay_out
);

	logic                         vld_s [1:QB];
	logic [LANES-1:0][DW-1:0]     rem_s [1:QB];
	logic [LANES-1:0][QB-1:0]     num_s [1:QB];
	logic [DW-1:0]                div_s [1:QB];
	logic [PW-1:0]                pay_s [1:QB];

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		logic                     p_vld;
		logic [LANES-1:0][DW-1:0] p_rem;
		logic [LANES-1:0][QB-1:0] p_num;
		logic [DW-1:0]            p_div;
		logic [PW-1:0]            p_pay;
		logic [LANES-1:0][DW-1:0] rem_nx;
		logic [LANES-1:0][QB-1:0] num_nx;

		if (k == 1) begin : g_first
			assign p_vld = in_vld;
			assign p_rem = rem_in;
			assign p_num = lo_in;
			assign p_div = div_in;
			assign p_pay = pay_in;
		end else begin : g_next
			assign p_vld = vld_s[k-1];
			assign p_rem = rem_s[k-1];
			assign p_num = num_s[k-1];
			assign p_div = div_s[k-1];
			assign p_pay = pay_s[k-1];
		end

		// dividend bits leave at the top, quotient bits enter at the bottom
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DW:0] trial;
			logic        ge;
			assign trial = {p_rem[l], p_num[l][QB-1]};
			assign ge = trial >= {1'b0, p_div};
			assign rem_nx[l] = ge ? DW'(trial - {1'b0, p_div}) : trial[DW-1:0];
			assign num_nx[l] = {p_num[l][QB-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k] <= rem_nx;
			num_s[k] <= num_nx;
			div_s[k] <= p_div;
			pay_s[k] <= p_pay;
		end
	end

	assign out_vld = vld_s[QB];
	assign quo_out = num_s[QB];
	assign pay_out = pay_s[QB];

endmodule

// ===== rtl/core/cpfo_sqrt_pipe.sv =====
`timescale 1ns / 1ps
// Integer square root, one root bit per stage (floor of sqrt).
// Standalone; payload rides along with the valid bit.
module cpfo_sqrt_pipe #(
	parameter int N  = 32,
	parameter int PW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  logic [2*N-1:0]  rad_in,
	input  logic [PW-1:0]   pay_in,
	output logic            out_vld,
	output logic [N-1:0]    root_out,
	output logic [PW-1:0]   pay_out
);

	logic            vld_s  [1:N];
	logic [N+1:0]    rem_s  [1:N];
	logic [N-1:0]    root_s [1:N];
	logic [2*N-1:0]  rad_s  [1:N];
	logic [PW-1:0]   pay_s  [1:N];

	for (genvar k = 1; k <= N; k++) begin : g_stage
		logic           p_vld;
		logic [N+1:0]   p_rem;
		logic [N-1:0]   p_root;
		logic [2*N-1:0] p_rad;
		logic [PW-1:0]  p_pay;
		logic [N+1:0]   shifted;
		logic [N+1:0]   trial;
		logic           ge;

		if (k == 1) begin : g_first
			assign p_vld  = in_vld;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_rad  = rad_in;
			assign p_pay  = pay_in;
		end else begin : g_next
			assign p_vld  = vld_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_root = root_s[k-1];
			assign p_rad  = rad_s[k-1];
			assign p_pay  = pay_s[k-1];
		end

		// remainder stays below 2*root+1, so its top two bits are zero here
		assign shifted = {p_rem[N-1:0], p_rad[2*N-1:2*N-2]};
		assign trial   = {p_root, 2'b01};
		assign ge      = shifted >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? shifted - trial : shifted;
			root_s[k] <= {p_root[N-2:0], ge};
			rad_s[k]  <= {p_rad[2*N-3:0], 2'b00};
			pay_s[k]  <= p_pay;
		end
	end

	assign out_vld  = vld_s[N];
	assign root_out = root_s[N];
	assign pay_out  = pay_s[N];

endmodule

// ===== rtl/core/capture_point_foot_offset_core.sv =====
`timescale 1ns / 1ps
// Foot offset core, top level: height select, T = sqrt(H/g), gain, length clamp.
// Depends on cpfo_pkg, cpfo_div_pipe, cpfo_sqrt_pipe and the macro header.
//
// channel  signals                                  word taken when
// item     start, busy, item                        start && !busy
// result   done, result                             done (one cycle)
// config   cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// A word enters every cycle; busy stays low.
// The path runs through the bit-per-stage height divider (QW = 31 + 2*FRAC_BITS
// quotient bits), two square roots (the first gives TW = (QW+1)/2 bits) and the
// clamp divider.
// Reset clears the valid chain and loads the register defaults.
// Results are strobed for one cycle on done; there is no back pressure.
`include "capture_point_foot_offset_core_macros.svh"
module capture_point_foot_offset_core #(
	parameter int FRAC_BITS = cpfo_pkg::CPFO_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  cpfo_pkg::cpfo_in_t               item,
	output logic                             done,
	output cpfo_pkg::cpfo_out_t              result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cpfo_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cpfo_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cpfo_pkg::*;

	localparam int QW  = HGT_W + 2 * FRAC_BITS;
	localparam int TW  = (QW + 1) / 2;
	localparam int TL  = TW / 2;
	localparam int KW  = GAIN_W + TW;
	localparam int KL  = KW / 2;
	localparam int FW  = KW + MAG_W;
	localparam int MW  = FW - 2 * FRAC_BITS;
	localparam int BLW = $clog2(MW + 1);
	localparam int SQW = 2 * LIM_W;
	localparam int LAT = QW + TW + 73;

	typedef struct packed {
		logic [MAG_W-1:0] mag_x;
		logic [MAG_W-1:0] mag_y;
		logic             neg_x;
		logic             neg_y;
		logic             nvh;
	} diff_t;

	typedef struct packed {
		logic [LIM_W-1:0] ms_x;
		logic [LIM_W-1:0] ms_y;
		logic [31:0]      sat_x;
		logic [31:0]      sat_y;
		logic             over;
		logic             neg_x;
		logic             neg_y;
		logic             nvh;
	} clamp_t;

	// configuration registers
	logic [GAIN_W-1:0] gain_q;
	logic [GRAV_W-1:0] grav_q;
	logic [HGT_W-1:0]  hov_q;
	logic [HGT_W-1:0]  nom_q;
	logic [LIM_W-1:0]  lim_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RST;
			grav_q <= GRAV_RST;
			hov_q  <= HOV_RST;
			nom_q  <= NOM_RST;
			lim_q  <= LIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cpfo_cfg_idx_t'(cfg_index))
				CFG_GAIN:    gain_q <= cfg_data[GAIN_W-1:0];
				CFG_GRAVITY: grav_q <= cfg_data[GRAV_W-1:0];
				CFG_HGT_OVR: hov_q  <= cfg_data[HGT_W-1:0];
				CFG_NOM_HGT: nom_q  <= cfg_data[HGT_W-1:0];
				CFG_MAX_OFS: lim_q  <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: height choice and velocity error
	logic              acc;
	logic              mh_pos;
	logic [HGT_W-1:0]  hgt_sel;
	logic [MAG_W:0]    dx, dy;
	diff_t             diff_nx;
	logic              vld_s1;
	logic [HGT_W-1:0]  hgt_s1;
	diff_t             diff_s1;

	assign acc     = start && !busy;
	assign mh_pos  = !item.measured_height[31] && (item.measured_height != '0);
	assign hgt_sel = (hov_q != '0) ? hov_q :
	                 mh_pos ? item.measured_height[HGT_W-1:0] : nom_q;
	assign dx = {item.measured_vel_x[31], item.measured_vel_x}
	          - {item.commanded_vel_x[31], item.commanded_vel_x};
	assign dy = {item.measured_vel_y[31], item.measured_vel_y}
	          - {item.commanded_vel_y[31], item.commanded_vel_y};

	always_comb begin
		diff_nx.neg_x = dx[MAG_W];
		diff_nx.neg_y = dy[MAG_W];
		diff_nx.mag_x = dx[MAG_W] ? MAG_W'(~dx + 1'b1) : dx[MAG_W-1:0];
		diff_nx.mag_y = dy[MAG_W] ? MAG_W'(~dy + 1'b1) : dy[MAG_W-1:0];
		diff_nx.nvh   = (hgt_sel == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		hgt_s1  <= hgt_sel;
		diff_s1 <= diff_nx;
	end

	// H * 2^(2F) / g
	logic [GRAV_W-1:0] grav_eff;
	logic              q_vld;
	logic [QW-1:0]     q_quo;
	diff_t             q_pay;

	assign grav_eff = (grav_q == '0) ? GRAV_W'(1) : grav_q;

	cpfo_div_pipe #(
		.DW    (GRAV_W),
		.QB    (QW),
		.LANES (1),
		.PW    ($bits(diff_t))
	) u_hdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s1),
		.rem_in  ('0),
		.lo_in   ({hgt_s1, {(2 * FRAC_BITS){1'b0}}}),
		.div_in  (grav_eff),
		.pay_in  (diff_s1),
		.out_vld (q_vld),
		.quo_out (q_quo),
		.pay_out (q_pay)
	);

	logic          t_vld;
	logic [TW-1:0] t_root;
	diff_t         t_pay;

	cpfo_sqrt_pipe #(
		.N  (TW),
		.PW ($bits(diff_t))
	) u_tsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (q_vld),
		.rad_in   ({{(2 * TW - QW){1'b0}}, q_quo}),
		.pay_in   (q_pay),
		.out_vld  (t_vld),
		.root_out (t_root),
		.pay_out  (t_pay)
	);

	// stages 2-5: K = gain * T, then m = K * |e| >> 2F, in partial products
	logic                       vld_s2, vld_s3, vld_s4, vld_s5;
	logic [GAIN_W+TL-1:0]       pk_lo_s2;
	logic [GAIN_W+TW-TL-1:0]    pk_hi_s2;
	logic [KW-1:0]              k_s3;
	logic [KL+MAG_W-1:0]        px_lo_s4, py_lo_s4;
	logic [KW-KL+MAG_W-1:0]     px_hi_s4, py_hi_s4;
	logic [MW-1:0]              mx_s5, my_s5;
	diff_t                      diff_s2, diff_s3, diff_s4, diff_s5;
	logic [FW-1:0]              fx, fy;

	assign fx = FW'(px_lo_s4) + (FW'(px_hi_s4) << KL);
	assign fy = FW'(py_lo_s4) + (FW'(py_hi_s4) << KL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s2 <= t_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		pk_lo_s2 <= gain_q * t_root[TL-1:0];
		pk_hi_s2 <= gain_q * t_root[TW-1:TL];
		diff_s2  <= t_pay;
		k_s3     <= KW'(pk_lo_s2) + (KW'(pk_hi_s2) << TL);
		diff_s3  <= diff_s2;
		px_lo_s4 <= k_s3[KL-1:0] * diff_s3.mag_x;
		px_hi_s4 <= k_s3[KW-1:KL] * diff_s3.mag_x;
		py_lo_s4 <= k_s3[KL-1:0] * diff_s3.mag_y;
		py_hi_s4 <= k_s3[KW-1:KL] * diff_s3.mag_y;
		diff_s4  <= diff_s3;
		mx_s5    <= fx[FW-1:2*FRAC_BITS];
		my_s5    <= fy[FW-1:2*FRAC_BITS];
		diff_s5  <= diff_s4;
	end

	// stage 6: common normalizing shift and saturated fallback values
	function automatic logic [31:0] sat32(input logic [MW-1:0] m, input logic neg);
		logic [31:0] r;
		if (neg) begin
			r = (m > MW'(32'h8000_0000)) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
		end else begin
			r = (m > MW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : m[31:0];
		end
		return r;
	endfunction

	logic [MW-1:0]  orv;
	logic [BLW-1:0] blen;
	logic [BLW-1:0] shamt;
	clamp_t         cl_nx;
	logic           vld_s6, vld_s7, vld_s8;
	clamp_t         cl_s6, cl_s7, cl_s8;
	logic           big_s6, big_s7;

	assign orv = mx_s5 | my_s5;

	always_comb begin
		blen = '0;
		for (int i = 0; i < MW; i++) begin
			if (orv[i]) begin
				blen = BLW'(i + 1);
			end
		end
	end

	assign shamt = (blen > BLW'(LIM_W)) ? blen - BLW'(LIM_W) : '0;

	always_comb begin
		cl_nx.ms_x  = LIM_W'(mx_s5 >> shamt);
		cl_nx.ms_y  = LIM_W'(my_s5 >> shamt);
		cl_nx.sat_x = sat32(mx_s5, diff_s5.neg_x);
		cl_nx.sat_y = sat32(my_s5, diff_s5.neg_y);
		cl_nx.over  = 1'b0;
		cl_nx.neg_x = diff_s5.neg_x;
		cl_nx.neg_y = diff_s5.neg_y;
		cl_nx.nvh   = diff_s5.nvh;
	end

	// stages 7-8: squared length against squared limit
	logic [SQW-1:0] sq_x_s7, sq_y_s7, lim2_s7;
	logic [SQW:0]   sq_sum;
	logic [SQW:0]   sum_s8;
	clamp_t         cl_ov;

	assign sq_sum = {1'b0, sq_x_s7} + {1'b0, sq_y_s7};

	always_comb begin
		cl_ov      = cl_s7;
		cl_ov.over = (lim_q != '0) && !cl_s7.nvh && (big_s7 || (sq_sum > {1'b0, lim2_s7}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		cl_s6   <= cl_nx;
		big_s6  <= |orv[MW-1:LIM_W];
		sq_x_s7 <= cl_s6.ms_x * cl_s6.ms_x;
		sq_y_s7 <= cl_s6.ms_y * cl_s6.ms_y;
		lim2_s7 <= lim_q * lim_q;
		cl_s7   <= cl_s6;
		big_s7  <= big_s6;
		sum_s8  <= sq_sum;
		cl_s8   <= cl_ov;
	end

	logic             l_vld;
	logic [LEN_W-1:0] l_root;
	clamp_t           l_pay;

	cpfo_sqrt_pipe #(
		.N  (LEN_W),
		.PW ($bits(clamp_t))
	) u_lsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s8),
		.rad_in   ({{(2 * LEN_W - SQW - 1){1'b0}}, sum_s8}),
		.pay_in   (cl_s8),
		.out_vld  (l_vld),
		.root_out (l_root),
		.pay_out  (l_pay)
	);

	// stage 9: numerators m * limit; quotient does not exceed the limit
	logic                         vld_s9;
	logic [LEN_W-1:0]             l2_s9;
	logic [SQW-1:0]               nx_s9, ny_s9;
	clamp_t                       cl_s9;
	logic [1:0][LEN_W-1:0]        crem;
	logic [1:0][LIM_W-1:0]        clo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else begin
			vld_s9 <= l_vld;
		end
	end

	always_ff @(posedge clk) begin
		l2_s9 <= (l_root == '0) ? LEN_W'(1) : l_root;
		nx_s9 <= l_pay.ms_x * lim_q;
		ny_s9 <= l_pay.ms_y * lim_q;
		cl_s9 <= l_pay;
	end

	assign crem[0] = {1'b0, nx_s9[SQW-1:LIM_W]};
	assign crem[1] = {1'b0, ny_s9[SQW-1:LIM_W]};
	assign clo[0]  = nx_s9[LIM_W-1:0];
	assign clo[1]  = ny_s9[LIM_W-1:0];

	logic                  c_vld;
	logic [1:0][LIM_W-1:0] c_quo;
	clamp_t                c_pay;

	cpfo_div_pipe #(
		.DW    (LEN_W),
		.QB    (LIM_W),
		.LANES (2),
		.PW    ($bits(clamp_t))
	) u_cdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s9),
		.rem_in  (crem),
		.lo_in   (clo),
		.div_in  (l2_s9),
		.pay_in  (cl_s9),
		.out_vld (c_vld),
		.quo_out (c_quo),
		.pay_out (c_pay)
	);

	// output register
	cpfo_out_t res_nx;
	cpfo_out_t result_q;
	logic      done_q;
	logic [31:0] cq_x, cq_y;

	assign cq_x = c_pay.neg_x ? (~{1'b0, c_quo[0]} + 32'd1) : {1'b0, c_quo[0]};
	assign cq_y = c_pay.neg_y ? (~{1'b0, c_quo[1]} + 32'd1) : {1'b0, c_quo[1]};

	always_comb begin
		res_nx.no_valid_height = c_pay.nvh;
		res_nx.was_clamped     = c_pay.over;
		if (c_pay.nvh) begin
			res_nx.offset_x = '0;
			res_nx.offset_y = '0;
		end else if (c_pay.over) begin
			res_nx.offset_x = cq_x;
			res_nx.offset_y = cq_y;
		end else begin
			res_nx.offset_x = c_pay.sat_x;
			res_nx.offset_y = c_pay.sat_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= c_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_nx;
	end

	assign done   = done_q;
	assign result = result_q;

	`CPFO_ASSERT_IMPL(a_latency, clk, arst_n, done, $past(acc, LAT))
	`CPFO_ASSERT_IMPL(a_nvh_zero, clk, arst_n, done && result.no_valid_height, (result.offset_x == '0) && (result.offset_y == '0) && !result.was_clamped)
	`CPFO_ASSERT_IMPL(a_clamp_lim, clk, arst_n, done && result.was_clamped, lim_q != '0)

endmodule
